@@ rtl/hashed_bucket_table_depth_replace_unit_defines.svh @@
// Assertion macros for the hashed bucket table.
`ifndef HASHED_BUCKET_TABLE_DEPTH_REPLACE_UNIT_DEFINES_SVH
`define HASHED_BUCKET_TABLE_DEPTH_REPLACE_UNIT_DEFINES_SVH

// same-cycle implication
`define HBT_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define HBT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/hbt_pkg.sv @@
// Shared constants and types for the hashed bucket table.
package hbt_pkg;

   localparam int unsigned TABLE_BUCKETS_DEF = 1024;
   localparam int unsigned WAYS_DEF          = 4;
   localparam int unsigned INVALID_CODE_DEF  = 3;

   localparam int unsigned KEY_W     = 64;
   localparam int unsigned WORD_W    = 64;
   localparam int unsigned IDXB_W    = 4;
   localparam int unsigned KEY_IDX_W = 15;
   localparam int unsigned WAY_W     = 3;
   localparam int unsigned SLOT_W    = 2;
   localparam int unsigned DEPTH_W   = 16;

   localparam logic [IDXB_W-1:0]         INDEX_BITS_RESET = 4'd10;
   localparam logic signed [DEPTH_W-1:0] DEPTH_BOUND      = 16'sd32000;

   localparam logic OP_LOOKUP = 1'b0;
   localparam logic OP_INSERT = 1'b1;

   typedef struct packed {
      logic             clear;
      logic             valid;
      logic             insert;
      logic [WAY_W-1:0] way;
   } eval_ctl_type;

   typedef struct packed {
      logic                       found;
      logic [WAY_W-1:0]           found_way;
      logic [WORD_W-1:0]          found_word;
      logic signed [DEPTH_W-1:0]  low_depth;
      logic [WAY_W-1:0]           best_way;
   } scan_result_type;

endpackage

@@ rtl/hashed_bucket_table_depth_replace_unit.sv @@
// Top level: sequencer, bucket store and response register of the hash table.
//
//  channel   direction  handshake             payload
//  request   in         start & !busy         req_operation .. req_age
//  response  out        rsp_valid (1 cycle)   rsp_hit, rsp_entry_word, rsp_slot
//  csr       in         csr_wr_en             csr_wr_data (index_bits)
//
// An item goes from accept to rsp_valid through the bucket modulo unit, the
// one-slot-per-cycle read port scan and its drain, decide and write-back in
// ST_DONE, and the response register. No new item is accepted while busy, so
// the block cannot take one before the last is through.
// After reset a clearing pass writes each of the TABLE_BUCKETS * WAYS slots
// (4096 by default) once, with busy high. The receiver cannot stall.
`include "hashed_bucket_table_depth_replace_unit_defines.svh"

module hashed_bucket_table_depth_replace_unit
   import hbt_pkg::*;
#(
   parameter int unsigned TABLE_BUCKETS = TABLE_BUCKETS_DEF,
   parameter int unsigned WAYS          = WAYS_DEF,
   parameter int unsigned INVALID_CODE  = INVALID_CODE_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic                      req_operation,
   input  logic [KEY_W-1:0]          req_key,
   input  logic [15:0]               req_best_move,
   input  logic signed [15:0]        req_search_depth,
   input  logic signed [15:0]        req_score,
   input  logic [7:0]                req_cutoff_type,
   input  logic [7:0]                req_age,
   output logic                      rsp_valid,
   output logic                      rsp_hit,
   output logic [WORD_W-1:0]         rsp_entry_word,
   output logic [SLOT_W-1:0]         rsp_slot,
   input  logic                      csr_wr_en,
   input  logic [IDXB_W-1:0]         csr_wr_data
);

   localparam int unsigned SLOTS = TABLE_BUCKETS * WAYS;
   localparam int unsigned AW    = $clog2(SLOTS);
   localparam int unsigned BW    = $clog2(TABLE_BUCKETS);
   localparam int unsigned WCW   = $clog2(WAYS + 1);
   localparam int unsigned RAM_W = KEY_W + WORD_W;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_MAP   = 3'd2;
   localparam logic [2:0] ST_SCAN  = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   localparam logic [WORD_W-1:0] EMPTY_WORD = WORD_W'(8'(INVALID_CODE)) << 48;

   logic [2:0]           state_ff, state_in;
   logic [AW-1:0]        clr_ff;
   logic [IDXB_W-1:0]    index_bits_ff;
   logic                 op_ff;
   logic [KEY_W-1:0]     key_ff;
   logic [WORD_W-1:0]    word_ff;
   logic [AW-1:0]        base_ff;
   logic [WCW-1:0]       way_ff;
   logic                 pend_ff;
   logic [WAY_W-1:0]     pend_way_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_hit_ff;
   logic [WORD_W-1:0]    rsp_word_ff;
   logic [SLOT_W-1:0]    rsp_slot_ff;

   logic                 accept;
   logic                 issue;
   logic [KEY_IDX_W-1:0] idx_mask;
   logic [KEY_IDX_W-1:0] masked_key;
   logic                 map_done;
   logic [BW-1:0]        bucket;
   eval_ctl_type         eval_ctl;
   scan_result_type      scan;
   logic [WAY_W-1:0]     target;
   logic                 ram_wr_en;
   logic [AW-1:0]        ram_wr_addr;
   logic [RAM_W-1:0]     ram_wr_data;
   logic [RAM_W-1:0]     ram_rd_data;

   assign busy       = state_ff != ST_IDLE;
   assign accept     = start && !busy;
   assign issue      = (state_ff == ST_SCAN) && (way_ff != WCW'(WAYS));
   assign idx_mask   = KEY_IDX_W'((16'd1 << index_bits_ff) - 16'd1);
   assign masked_key = req_key[KEY_IDX_W-1:0] & idx_mask;

   hbt_bucket_map #(
      .BUCKETS (TABLE_BUCKETS)
   ) u_map (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .masked_key (masked_key),
      .done       (map_done),
      .bucket     (bucket)
   );

   assign eval_ctl.clear  = accept;
   assign eval_ctl.valid  = pend_ff;
   assign eval_ctl.insert = op_ff == OP_INSERT;
   assign eval_ctl.way    = pend_way_ff;

   hbt_way_eval #(
      .INVALID_CODE (INVALID_CODE)
   ) u_eval (
      .clock      (clock),
      .reset      (reset),
      .ctl        (eval_ctl),
      .key        (key_ff),
      .slot_word  (ram_rd_data[WORD_W-1:0]),
      .slot_check (ram_rd_data[RAM_W-1:WORD_W]),
      .result     (scan)
   );

   always_comb begin
      if (scan.found) begin
         target = scan.found_way;
      end else if (signed'(word_ff[31:16]) >= scan.low_depth) begin
         target = scan.best_way;
      end else begin
         target = '0;
      end
   end

   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = clr_ff;
      ram_wr_data = {{KEY_W{1'b0}}, EMPTY_WORD};
      if (state_ff == ST_CLEAR) begin
         ram_wr_en = 1'b1;
      end else if (state_ff == ST_DONE && op_ff == OP_INSERT) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = base_ff + AW'(target);
         ram_wr_data = {key_ff ^ word_ff, word_ff};
      end
   end

   hbt_ram #(
      .WIDTH (RAM_W),
      .DEPTH (SLOTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (issue),
      .rd_addr (base_ff + AW'(way_ff)),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == AW'(SLOTS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_MAP;
            end
         end
         ST_MAP: begin
            if (map_done) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!issue && !pend_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         index_bits_ff <= INDEX_BITS_RESET;
         pend_ff       <= 1'b0;
         way_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= state_ff == ST_DONE;
         pend_ff      <= issue;
         if (state_ff == ST_CLEAR) begin
            clr_ff <= clr_ff + AW'(1);
         end
         if (csr_wr_en) begin
            index_bits_ff <= csr_wr_data;
         end
         if (accept) begin
            way_ff <= '0;
         end else if (issue) begin
            way_ff <= way_ff + WCW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= req_operation;
         key_ff  <= req_key;
         word_ff <= {req_age, req_cutoff_type, req_score, req_search_depth, req_best_move};
      end
      if (map_done) begin
         base_ff <= AW'(AW'(bucket) * AW'(WAYS));
      end
      if (issue) begin
         pend_way_ff <= WAY_W'(way_ff);
      end
      if (state_ff == ST_DONE) begin
         if (op_ff == OP_INSERT) begin
            rsp_hit_ff  <= 1'b1;
            rsp_word_ff <= word_ff;
            rsp_slot_ff <= target[SLOT_W-1:0];
         end else begin
            rsp_hit_ff  <= scan.found;
            rsp_word_ff <= scan.found ? scan.found_word : '0;
            rsp_slot_ff <= scan.found ? scan.found_way[SLOT_W-1:0] : '0;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_entry_word = rsp_word_ff;
   assign rsp_slot       = rsp_slot_ff;

   `HBT_ASSERT_IMPL(a_rsp_after_done, clock, reset, rsp_valid_ff, $past(state_ff) == ST_DONE, "response beat without a finished item")
   `HBT_ASSERT_IMPL(a_miss_is_zero, clock, reset, rsp_valid_ff && !rsp_hit_ff, rsp_word_ff == '0 && rsp_slot_ff == '0, "miss beat carries nonzero payload")
   `HBT_ASSERT_NEXT(a_pend_way_range, clock, reset, issue, pend_way_ff < WAY_W'(WAYS), "scan read beyond last way")

endmodule

@@ rtl/hbt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module hbt_ram #(
   parameter int unsigned WIDTH = 128,
   parameter int unsigned DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/hbt_bucket_map.sv @@
// Two-stage reduction of the masked key modulo the bucket count.
module hbt_bucket_map
   import hbt_pkg::*;
#(
   parameter int unsigned BUCKETS = TABLE_BUCKETS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         load,
   input  logic [KEY_IDX_W-1:0]         masked_key,
   output logic                         done,
   output logic [$clog2(BUCKETS)-1:0]   bucket
);

   localparam int unsigned NB    = $clog2(BUCKETS);
   localparam int unsigned SHIFT = KEY_IDX_W + NB;
   localparam longint unsigned RECIP =
      ((64'd1 << SHIFT) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
   localparam int unsigned RW = $clog2(RECIP + 1);
   localparam int unsigned PW = KEY_IDX_W + RW;

   logic                 stage1_ff;
   logic                 done_ff;
   logic [KEY_IDX_W-1:0] key_ff;
   logic [PW-1:0]        prod_ff;
   logic [NB-1:0]        bucket_ff;
   logic [KEY_IDX_W-1:0] quot;
   logic [KEY_IDX_W-1:0] rem;

   assign quot = KEY_IDX_W'(prod_ff >> SHIFT);
   assign rem  = key_ff - KEY_IDX_W'(quot * KEY_IDX_W'(BUCKETS));

   always_ff @(posedge clock) begin
      if (reset) begin
         stage1_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         stage1_ff <= load;
         done_ff   <= stage1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         key_ff  <= masked_key;
         prod_ff <= PW'(masked_key) * PW'(RECIP);
      end
      if (stage1_ff) begin
         bucket_ff <= NB'(rem);
      end
   end

   assign done   = done_ff;
   assign bucket = bucket_ff;

endmodule

@@ rtl/hbt_way_eval.sv @@
// Per-way compare unit: key match, empty-slot and shallowest-depth tracking (way 0 excluded).
module hbt_way_eval
   import hbt_pkg::*;
#(
   parameter int unsigned INVALID_CODE = INVALID_CODE_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  eval_ctl_type    ctl,
   input  logic [KEY_W-1:0]  key,
   input  logic [WORD_W-1:0] slot_word,
   input  logic [KEY_W-1:0]  slot_check,
   output scan_result_type result
);

   logic                      found_ff;
   logic [WAY_W-1:0]          found_way_ff;
   logic [WORD_W-1:0]         found_word_ff;
   logic signed [DEPTH_W-1:0] min_ff;
   logic [WAY_W-1:0]          best_ff;
   logic                      key_match;
   logic                      empty;
   logic                      take;
   logic signed [DEPTH_W-1:0] depth;

   assign key_match = (slot_check ^ slot_word) == key;
   assign empty     = slot_word[55:48] == 8'(INVALID_CODE);
   assign take      = key_match || (ctl.insert && empty);
   assign depth     = signed'(slot_word[31:16]);

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (ctl.clear) begin
         found_ff <= 1'b0;
      end else if (ctl.valid && !found_ff && take) begin
         found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.clear) begin
         found_way_ff  <= '0;
         found_word_ff <= '0;
         min_ff        <= DEPTH_BOUND;
         best_ff       <= '0;
      end else if (ctl.valid) begin
         if (!found_ff && take) begin
            found_way_ff  <= ctl.way;
            found_word_ff <= slot_word;
         end
         if (ctl.way != '0 && depth < min_ff) begin
            min_ff  <= depth;
            best_ff <= ctl.way;
         end
      end
   end

   assign result.found      = found_ff;
   assign result.found_way  = found_way_ff;
   assign result.found_word = found_word_ff;
   assign result.low_depth  = min_ff;
   assign result.best_way   = best_ff;

endmodule
